[rtl/ntisd_pkg.sv]
// Shared types, command codes and status codes for the name table core.
`timescale 1ns / 1ps
`default_nettype none

package ntisd_pkg;

  // Command codes carried in the input tuser.
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] KIND_LIST   = 2'd3;

  // Status codes carried in the output tuser.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_LISTED    = 3'd4;

  // A list command reports at most this many entries.
  localparam int LIST_CAP = 16;

  // Field widths of one result item.
  localparam int SLOT_W = 4;
  localparam int NAME_W = 64;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [NAME_W-1:0] name;
    logic              last;
  } result_t;

  function automatic result_t make_res(input logic [2:0] status,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [NAME_W-1:0] name,
                                       input logic last);
    result_t r;
    r.status = status;
    r.slot   = slot;
    r.name   = name;
    r.last   = last;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ntisd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ntisd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/ntisd_ctrl.sv]
// Command sequencer: scans, updates and lists the name table held in RAM.
`timescale 1ns / 1ps
`default_nettype none

module ntisd_ctrl
  import ntisd_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int NAME_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_key,
  output logic             res_valid,
  input  wire logic        res_ready,
  output result_t          res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = CW + 6;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DRD  = 3'd2;
  localparam logic [2:0] S_DWR  = 3'd3;
  localparam logic [2:0] S_LRD  = 3'd4;
  localparam logic [2:0] S_LDAT = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]           state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        idx, idx_next;
  logic                 rd_vld, rd_vld_next;
  logic [AW-1:0]        rd_idx, rd_idx_next;
  logic [AW-1:0]        hit, hit_next;
  logic [1:0]           kind_r, kind_r_next;
  logic [NAME_BITS-1:0] key_r, key_r_next;
  result_t              res_next;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [NAME_BITS-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [NAME_BITS-1:0] rdata;

  logic                 issue;
  logic                 match;
  logic                 scan_end;
  logic [CW-1:0]        cnt_dec;
  logic [LW-1:0]        idx_inc;
  logic                 list_last;

  ntisd_ram #(
    .WIDTH(NAME_BITS),
    .DEPTH(DEPTH)
  ) u_names (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Scan bookkeeping: one read issued per cycle, compared in the cycle after.
  assign issue     = (state == S_SCAN) && (idx < count);
  assign match     = rd_vld && (rdata == key_r);
  assign scan_end  = rd_vld && (match || ((CW'(rd_idx) + CW'(1)) == count));
  assign cnt_dec   = count - CW'(1);
  assign idx_inc   = LW'(idx) + LW'(1);
  assign list_last = (idx_inc == LW'(count)) || (idx_inc == LW'(LIST_CAP));

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  // Next-state logic for the sequencer.
  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    rd_vld_next = 1'b0;
    rd_idx_next = idx[AW-1:0];
    hit_next    = hit;
    kind_r_next = kind_r;
    key_r_next  = key_r;
    res_next    = res;
    we          = 1'b0;
    waddr       = count[AW-1:0];
    wdata       = in_key[NAME_BITS-1:0];
    raddr       = idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_r_next = in_kind;
          key_r_next  = in_key[NAME_BITS-1:0];
          idx_next    = '0;
          case (in_kind)
            KIND_CREATE: begin
              if (count >= CW'(DEPTH)) begin
                res_next = make_res(ST_FULL, '0, '0, 1'b1);
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
                res_next   = make_res(ST_OK, SLOT_W'(count), '0, 1'b1);
              end
              state_next = S_EMIT;
            end
            KIND_DELETE, KIND_SEARCH: begin
              if (count == '0) begin
                res_next   = make_res(ST_NOT_FOUND, '0, '0, 1'b1);
                state_next = S_EMIT;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              if (count == '0) begin
                res_next   = make_res(ST_EMPTY, '0, '0, 1'b1);
                state_next = S_EMIT;
              end else begin
                state_next = S_LRD;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue) begin
          idx_next = idx + CW'(1);
        end
        rd_vld_next = issue && !scan_end;
        if (match) begin
          if (kind_r == KIND_SEARCH) begin
            res_next   = make_res(ST_OK, SLOT_W'(rd_idx), '0, 1'b1);
            state_next = S_EMIT;
          end else begin
            hit_next   = rd_idx;
            state_next = S_DRD;
          end
        end else if (scan_end) begin
          res_next   = make_res(ST_NOT_FOUND, '0, '0, 1'b1);
          state_next = S_EMIT;
        end
      end

      // Fetch the last entry to move it into the freed slot.
      S_DRD: begin
        raddr      = cnt_dec[AW-1:0];
        state_next = S_DWR;
      end

      S_DWR: begin
        we         = 1'b1;
        waddr      = hit;
        wdata      = rdata;
        count_next = cnt_dec;
        res_next   = make_res(ST_OK, SLOT_W'(hit), '0, 1'b1);
        state_next = S_EMIT;
      end

      S_LRD: begin
        state_next = S_LDAT;
      end

      S_LDAT: begin
        res_next   = make_res(ST_LISTED, SLOT_W'(idx), NAME_W'(rdata), list_last);
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (res_ready) begin
          if (res.last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = S_LRD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_vld <= rd_vld_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    rd_idx <= rd_idx_next;
    hit    <= hit_next;
    kind_r <= kind_r_next;
    key_r  <= key_r_next;
    res    <= res_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_create_inc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_kind == KIND_CREATE && count < CW'(DEPTH))
      |=> count == $past(count) + CW'(1))
    else $error("create did not grow the table");

  a_delete_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_DWR) |=> count == $past(count) - CW'(1))
    else $error("delete did not shrink the table");

  a_rdvld_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == S_SCAN)
    else $error("scan compare outside of a scan");

endmodule

`default_nettype wire

[rtl/name_table_insert_delete_search_core.sv]
// Top level of the name table core: stream ports and the result output register.
//
// Usage: the s_ channel takes one command item: s_tuser is the command
// (create, delete, search, list) and s_tdata the name key, up to 8 ASCII
// bytes zero padded; only its low NAME_BITS bits are stored and compared.
// The m_ channel returns result items: m_tuser is the status, m_tdata holds
// the slot and the listed name, m_tlast marks the final result of a command.
// Create, delete and search give one result each; list gives one result per
// entry (at most sixteen), or a single empty result.
// Commands run one at a time; s_tready is high only while no command is in
// progress. The names live in a RAM with one write and one registered read
// port, and that read port shapes the steps of each command:
//   create: one write, then the result.
//   search: a pipelined scan, one entry read per cycle.
//   delete: scan, read of the last entry, write back.
//   list:   each entry is read, captured and emitted before the next read.
// Reset (rst, synchronous) empties the table; stored names are not cleared.
// A stalled receiver holds the result in the output register and the
// sequencer waits with the next result; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module name_table_insert_delete_search_core
  import ntisd_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int NAME_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [63:0] key_name
  input  wire logic [1:0]  s_tuser,   // [1:0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [3:0] slot, [67:4] entry_name, [71:68] zero
  output logic [2:0]       m_tuser,   // [2:0] status
  output logic             m_tlast
);

  logic    res_valid;
  logic    res_ready;
  result_t res;
  logic    out_vld;
  result_t out_res;

  ntisd_ctrl #(
    .DEPTH    (DEPTH),
    .NAME_BITS(NAME_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_key   (s_tdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Output register: refills in the cycle the current item leaves.
  assign res_ready = !out_vld || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (res_ready) begin
      out_vld <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {4'b0000, out_res.name, out_res.slot};
  assign m_tuser  = out_res.status;
  assign m_tlast  = out_res.last;

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the name table core: directed and random commands.
`timescale 1ns / 1ps

module tb;
  import ntisd_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS = 64;
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);
  localparam int POOL_SIZE = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0] s_tuser = KIND_CREATE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;

  // Expected directory contents and the results still owed by the block.
  logic [63:0] dir_names [TABLE_DEPTH];
  int dir_count = 0;
  result_t owed_results [$];
  logic [63:0] name_pool [POOL_SIZE];

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_left = 0;
  int quiet_cycles = 0;

  name_table_insert_delete_search_core #(
    .DEPTH(TABLE_DEPTH),
    .NAME_BITS(KEY_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  // Applies one command to the expected directory and queues its results.
  function automatic void predict_directory(input logic [1:0] kind, input logic [63:0] raw_key);
    logic [63:0] key;
    int hit;
    int n;
    result_t r;
    key = raw_key & KEY_MASK;
    r = '0;
    r.last = 1'b1;
    case (kind)
      KIND_CREATE: begin
        if (dir_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          dir_names[dir_count] = key;
          r.status = ST_OK;
          r.slot = 4'(dir_count);
          dir_count++;
        end
        owed_results.push_back(r);
      end
      KIND_DELETE, KIND_SEARCH: begin
        hit = -1;
        for (int i = 0; i < dir_count; i++) begin
          if (hit < 0 && dir_names[i] == key) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status = ST_OK;
          r.slot = 4'(hit);
          // A delete fills the hole with the last entry.
          if (kind == KIND_DELETE) begin
            dir_names[hit] = dir_names[dir_count - 1];
            dir_count--;
          end
        end
        owed_results.push_back(r);
      end
      default: begin
        if (dir_count == 0) begin
          r.status = ST_EMPTY;
          owed_results.push_back(r);
        end else begin
          n = (dir_count > LIST_CAP) ? LIST_CAP : dir_count;
          for (int i = 0; i < n; i++) begin
            r.status = ST_LISTED;
            r.slot = 4'(i);
            r.name = dir_names[i];
            r.last = (i == n - 1);
            owed_results.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // Offers one command item, with random idle cycles ahead of it, and
  // leaves tvalid high after the handshake.
  task automatic send_command(input logic [1:0] kind, input logic [63:0] key);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= key;
    do @(posedge clk); while (!s_tready);
    predict_directory(kind, key);
  endtask

  // Drops tvalid and waits until every owed result has come back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Mostly names from a small pool or the table itself, so that deletes
  // and searches hit; the rest are arbitrary 64-bit keys.
  function automatic logic [63:0] pick_key();
    int r;
    logic [63:0] k;
    r = $urandom_range(99);
    if (r < 45) begin
      k = name_pool[$urandom_range(POOL_SIZE - 1)];
    end else if (r < 70 && dir_count > 0) begin
      k = dir_names[$urandom_range(dir_count - 1)];
    end else begin
      k = {$urandom, $urandom};
    end
    return k;
  endfunction

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(99);
    // Lean toward deletes when the table is nearly full.
    if (dir_count >= TABLE_DEPTH - 2 && r < 30) return KIND_DELETE;
    if (r < 35) return KIND_CREATE;
    if (r < 60) return KIND_DELETE;
    if (r < 85) return KIND_SEARCH;
    return KIND_LIST;
  endfunction

  // Result checker: each accepted item against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: status %0d slot %0d",
                                  m_tuser, m_tdata[3:0]));
      end else begin
        want = owed_results.pop_front();
        if (m_tuser !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
        end
        if (m_tdata[3:0] !== want.slot) begin
          report_mismatch($sformatf("slot %0d, expected %0d", m_tdata[3:0], want.slot));
        end
        if (m_tdata[67:4] !== want.name) begin
          report_mismatch($sformatf("entry_name %h, expected %h", m_tdata[67:4], want.name));
        end
        if (m_tlast !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Search, delete and list on a table that has never held anything.
  task automatic test_empty_table();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_command(KIND_SEARCH, 64'h0000_0000_0000_0041);
    send_command(KIND_DELETE, {64{1'b1}});
    send_command(KIND_LIST, 64'h0);
    wait_for_results();
  endtask

  // Extreme keys, duplicates, delete with move of the last entry,
  // delete of the last entry itself, and emptying the table again.
  task automatic test_basic_commands();
    send_command(KIND_CREATE, 64'h0);
    send_command(KIND_CREATE, {64{1'b1}});
    send_command(KIND_CREATE, 64'h0000_0000_0000_0041);
    send_command(KIND_CREATE, 64'h0000_0000_0000_0041);
    send_command(KIND_SEARCH, 64'h0000_0000_0000_0041);
    send_command(KIND_SEARCH, {64{1'b1}});
    send_command(KIND_LIST, {64{1'b1}});
    send_command(KIND_DELETE, 64'h0000_0000_0000_0041);
    send_command(KIND_DELETE, {64{1'b1}});
    send_command(KIND_SEARCH, 64'h8000_0000_0000_0041);
    send_command(KIND_LIST, 64'h0);
    send_command(KIND_DELETE, 64'h0);
    send_command(KIND_DELETE, 64'h0000_0000_0000_0041);
    send_command(KIND_LIST, 64'h0);
    wait_for_results();
  endtask

  // Fill the table, create on a full table, and list all sixteen entries.
  task automatic test_full_table();
    send_idle_pct = 8;
    recv_stall_pct = 8;
    while (dir_count < TABLE_DEPTH) send_command(KIND_CREATE, pick_key());
    send_command(KIND_CREATE, 64'h0000_0000_0000_0042);
    send_command(KIND_LIST, 64'h0);
    send_command(KIND_SEARCH, dir_names[TABLE_DEPTH - 1]);
    send_command(KIND_DELETE, dir_names[TABLE_DEPTH - 1]);
    send_command(KIND_DELETE, dir_names[0]);
    send_command(KIND_LIST, 64'h0);
    wait_for_results();
  endtask

  // Long receiver hold-off while the sender keeps offering commands.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = HOLD_OFF_CYCLES;
    send_command(KIND_CREATE, pick_key());
    send_command(KIND_LIST, 64'h0);
    for (int i = 0; i < 6; i++) send_command(pick_kind(), pick_key());
    send_command(KIND_LIST, 64'h0);
    wait_for_results();
  endtask

  // Random commands with random names from a fresh pool.
  task automatic test_random_commands(input int n_items, input int idle_pct,
                                      input int stall_pct);
    int len;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int p = 0; p < POOL_SIZE; p++) begin
      name_pool[p] = '0;
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++) name_pool[p][8*b +: 8] = 8'($urandom_range(8'h21, 8'h7e));
    end
    for (int i = 0; i < n_items; i++) send_command(pick_kind(), pick_key());
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_basic_commands();
    test_random_commands(15, 0, 0);
    test_full_table();
    test_random_commands(15, 58, 0);
    test_backpressure();
    test_random_commands(15, 0, 58);
    test_random_commands(15, 8, 8);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
